/* rtl/srld_pkg.sv */
package srld_pkg;

    localparam int CFG_W     = 12;
    localparam int POS_W     = 13;
    localparam int LEN_W     = 9;
    localparam int REG_IDX_W = 3;

    localparam logic [7:0] LIT_TYPE = 8'hFF;
    localparam logic [2:0] LIT_CODE = 3'd7;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FORMAT  = 3'd0,
        REG_WIDTH   = 3'd1,
        REG_HEIGHT  = 3'd2,
        REG_LMARGIN = 3'd3,
        REG_TMARGIN = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        FMT_RAW          = 2'd0,
        FMT_PAIR         = 2'd1,
        FMT_PACKED       = 2'd2,
        FMT_PACKED_CLAMP = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_LITERAL = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    typedef struct packed {
        fmt_t             format_type;
        logic [CFG_W-1:0] sprite_height;
        logic [CFG_W-1:0] left_margin;
        logic [CFG_W-1:0] top_margin;
        logic [CFG_W-1:0] eff_width;
    } cfg_t;

    typedef struct packed {
        logic       first_byte;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic             sprite_done;
        logic             row_done;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic [LEN_W-1:0] run_length;
        logic [7:0]       pixel_value;
    } result_t;

endpackage

/* rtl/srld_cfg.sv */
module srld_cfg #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [srld_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [srld_pkg::CFG_W-1:0]     wr_data,
    output srld_pkg::cfg_t                 cfg
);
    import srld_pkg::*;

    localparam int WMAX = (1 << CFG_W) - 1;
    localparam int WCAP = (MAX_WIDTH > WMAX) ? WMAX : MAX_WIDTH;

    fmt_t             format_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] lmargin_reg;
    logic [CFG_W-1:0] tmargin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg  <= FMT_RAW;
            width_reg   <= CFG_W'(1);
            height_reg  <= CFG_W'(1);
            lmargin_reg <= '0;
            tmargin_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx_t'(wr_index))
                REG_FORMAT:  format_reg  <= fmt_t'(wr_data[1:0]);
                REG_WIDTH:   width_reg   <= wr_data;
                REG_HEIGHT:  height_reg  <= wr_data;
                REG_LMARGIN: lmargin_reg <= wr_data;
                REG_TMARGIN: tmargin_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.format_type   = format_reg;
        cfg.sprite_height = height_reg;
        cfg.left_margin   = lmargin_reg;
        cfg.top_margin    = tmargin_reg;
        cfg.eff_width     = (width_reg > CFG_W'(WCAP)) ? CFG_W'(WCAP) : width_reg;
    end

endmodule

/* rtl/srld_in_reg.sv */
module srld_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  srld_pkg::in_item_t s_item,
    input  logic               step,
    output logic               item_valid,
    output srld_pkg::in_item_t item
);
    import srld_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // The slot frees in the same cycle that its item is decoded.
    assign s_ready    = !valid_reg || step;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (step) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

/* rtl/srld_decode.sv */
module srld_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  srld_pkg::in_item_t item,
    input  srld_pkg::cfg_t     cfg,
    output logic               res_valid,
    output srld_pkg::result_t  res
);
    import srld_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [7:0]       held_reg, held_next;
    logic [LEN_W-1:0] lit_reg, lit_next;
    logic [CFG_W-1:0] filled_reg, filled_next;
    logic [CFG_W-1:0] rowidx_reg, rowidx_next;

    // Position after a first_byte has cleared it, then the run placement.
    phase_t           ph;
    logic [7:0]       held;
    logic [LEN_W-1:0] lit;
    logic [CFG_W-1:0] filled;
    logic [CFG_W-1:0] rowidx;
    logic             emit_en;
    logic [7:0]       emit_val;
    logic [LEN_W-1:0] emit_len;
    logic [LEN_W-1:0] hdr_len;
    logic [CFG_W-1:0] left;
    logic [CFG_W:0]   total;
    logic             rdone;
    logic [CFG_W-1:0] rowidx_inc;
    logic [7:0]       b;

    always_comb begin
        b      = item.data_byte;
        ph     = item.first_byte ? PH_HEADER : phase_reg;
        held   = item.first_byte ? 8'd0 : held_reg;
        lit    = item.first_byte ? '0 : lit_reg;
        filled = item.first_byte ? '0 : filled_reg;
        rowidx = item.first_byte ? '0 : rowidx_reg;

        left = (cfg.eff_width > filled) ? (cfg.eff_width - filled) : CFG_W'(1);

        // Header length for the packed formats, clamped to the row in the clamp format.
        hdr_len = {4'd0, b[4:0]} + LEN_W'(1);
        if (cfg.format_type == FMT_PACKED_CLAMP && {3'd0, hdr_len} > left) begin
            hdr_len = left[LEN_W-1:0];
        end

        phase_next = ph;
        held_next  = held;
        lit_next   = lit;
        emit_en    = 1'b0;
        emit_val   = b;
        emit_len   = LEN_W'(1);

        if (rowidx >= cfg.sprite_height) begin
            emit_en = 1'b0;
        end else if (cfg.format_type == FMT_RAW) begin
            phase_next = PH_HEADER;
            emit_en    = 1'b1;
        end else if (ph == PH_SKIP) begin
            lit_next = lit - LEN_W'(1);
            if (lit_next == '0) begin
                phase_next = PH_HEADER;
            end
        end else if (ph == PH_LITERAL) begin
            emit_en  = 1'b1;
            lit_next = lit - LEN_W'(1);
        end else if (cfg.format_type == FMT_PAIR) begin
            if (ph == PH_LENGTH) begin
                if (held == LIT_TYPE) begin
                    lit_next   = {1'b0, b} + LEN_W'(1);
                    phase_next = PH_LITERAL;
                end else begin
                    phase_next = PH_HEADER;
                    emit_en    = 1'b1;
                    emit_val   = held;
                    emit_len   = {1'b0, b} + LEN_W'(1);
                end
            end else begin
                held_next  = b;
                phase_next = PH_LENGTH;
            end
        end else begin
            if (b[7:5] == LIT_CODE) begin
                lit_next   = hdr_len;
                phase_next = PH_LITERAL;
            end else begin
                phase_next = PH_HEADER;
                emit_en    = 1'b1;
                emit_val   = {5'd0, b[7:5]};
                emit_len   = hdr_len;
            end
        end

        total      = {1'b0, filled} + {4'd0, emit_len};
        rdone      = total >= {1'b0, cfg.eff_width};
        rowidx_inc = rowidx + CFG_W'(1);

        filled_next = filled;
        rowidx_next = rowidx;
        if (emit_en) begin
            if (rdone) begin
                filled_next = '0;
                rowidx_next = rowidx_inc;
            end else begin
                filled_next = total[CFG_W-1:0];
            end
        end

        // A literal that ends the row drops the rest of its segment.
        if (emit_en && ph == PH_LITERAL && cfg.format_type != FMT_RAW) begin
            if (lit_next == '0) begin
                phase_next = PH_HEADER;
            end else if (rdone) begin
                phase_next = PH_SKIP;
            end
        end

        res_valid       = emit_en;
        res.pixel_value = emit_val;
        res.run_length  = emit_len;
        res.column      = {1'b0, cfg.left_margin} + {1'b0, filled};
        res.row         = {1'b0, cfg.top_margin} + {1'b0, rowidx};
        res.row_done    = rdone;
        res.sprite_done = rdone && (rowidx_inc >= cfg.sprite_height);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            held_reg   <= 8'd0;
            lit_reg    <= '0;
            filled_reg <= '0;
            rowidx_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            lit_reg    <= lit_next;
            filled_reg <= filled_next;
            rowidx_reg <= rowidx_next;
        end
    end

endmodule

/* rtl/srld_out_reg.sv */
module srld_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              res_valid,
    input  srld_pkg::result_t res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output srld_pkg::result_t m_res
);
    import srld_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

/* rtl/sprite_rle_row_decoder.sv */
// Channel  Direction  Transfer               Content
// s_       in         s_tvalid & s_tready    one encoded sprite byte
// m_       out        m_tvalid & m_tready    one placed pixel run
// cfg_     in         cfg_valid & cfg_ready  one register write
//
// One byte enters per cycle while m_ is not stalled; a byte waits in the input register
// until it is decoded, and its run (if any) is registered in the output register for m_.
// The row and parser counters update per decoded byte, so an unstalled rate is one byte per clock.
// Reset is synchronous on aresetn low and clears the valid, state and configuration registers to their defaults.
// A stalled m_ side holds one run; s_tready then drops once the input register is full.
module sprite_rle_row_decoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] first_byte

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] pixel_value, [16:8] run_length, [29:17] column, [42:30] row, [47:43] zero
    output logic [47:0]                    m_tdata,
    output logic                           m_tuser,   // [0] row_done
    output logic                           m_tlast,   // sprite_done

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srld_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [srld_pkg::CFG_W-1:0]     cfg_data
);
    import srld_pkg::*;

    cfg_t     cfg;
    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     step;
    logic     out_free;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign cfg_ready = 1'b1;

    srld_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign s_item.data_byte  = s_tdata;
    assign s_item.first_byte = s_tuser;

    srld_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decode only when the result register can take whatever comes out.
    assign step = item_valid && out_free;

    srld_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    srld_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {5'd0, m_res.row, m_res.column, m_res.run_length, m_res.pixel_value};
    assign m_tuser = m_res.row_done;
    assign m_tlast = m_res.sprite_done;

    a_sprite_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("sprite_done without row_done");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_res.run_length != '0)
        else $error("empty run on output");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> item_valid && m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule
